>>> rtl/core/jos_pkg.sv
// ---------------------------------------------------------------------------
// jos_pkg
// Shared widths, controller states and the command/status bundles that
// join the controller and the datapath of the survivor search.
// ---------------------------------------------------------------------------
package jos_pkg;

  localparam int SIZE_W       = 11;
  localparam int STEP_W       = 16;
  localparam int OUT_W        = 11;
  localparam int MAX_SIZE_DEF = 1024;
  // a step field of zero counts a full wrap of the 16-bit counter
  localparam int STEP_FULL    = 65536;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;    // capture a new request
    logic start;   // begin remainder of (pos + step) by idx
    logic shift;   // one radix-4 remainder step
    logic commit;  // write remainder back to pos, advance idx
    logic emit;    // load the result register
  } cmd_t;

  typedef struct packed {
    logic done;      // idx has passed the circle size
    logic div_last;  // this shift is the final remainder step
  } status_t;

endpackage

>>> rtl/core/josephus_survivor.sv
// ---------------------------------------------------------------------------
// josephus_survivor
// Last survivor of Josephus elimination for a given circle size and step.
// ---------------------------------------------------------------------------
// One request in, one result out. The block evaluates the recurrence
// pos = (pos + step) mod i for i = 2 .. size with a shared restoring
// remainder unit that retires two dividend bits per cycle; each i passes
// through a check state and then the remainder steps. One request is
// worked at a time; a finished result waits in the output register while
// the next request is taken. A size of 0 acts as 1, sizes above MAX_SIZE
// saturate to MAX_SIZE, and a step of 0 acts as 65536.
// ---------------------------------------------------------------------------
module josephus_survivor import jos_pkg::*; #(
  parameter int MAX_SIZE = MAX_SIZE_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [SIZE_W-1:0] circle_size,
  input  logic [STEP_W-1:0] step_count,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [OUT_W-1:0]  survivor
);

  cmd_t    cmd;
  status_t status;

  jos_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  jos_dpath #(
    .MAX_SIZE (MAX_SIZE)
  ) u_dpath (
    .clk         (clk),
    .circle_size (circle_size),
    .step_count  (step_count),
    .cmd         (cmd),
    .status      (status),
    .survivor    (survivor)
  );

endmodule

>>> rtl/core/jos_ctrl.sv
// ---------------------------------------------------------------------------
// jos_ctrl
// Sequencer for the survivor search: takes a request, runs one remainder
// pass per circle size from 2 up to the requested size, then hands the
// result to the output register.
// ---------------------------------------------------------------------------
module jos_ctrl import jos_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.done) begin
          state_next = ST_FINISH;
        end else begin
          cmd.start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.shift = 1'b1;
        if (status.div_last) begin
          cmd.commit = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_FINISH: begin
        // hold until the output slot is free or being drained
        if (!out_valid || !out_stall) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    out_valid_next = cmd.emit | (out_valid & out_stall);
  end

endmodule

>>> rtl/core/jos_dpath.sv
// ---------------------------------------------------------------------------
// jos_dpath
// Datapath for the survivor recurrence pos = (pos + step) mod idx, with a
// restoring remainder unit that retires two dividend bits per cycle.
// ---------------------------------------------------------------------------
module jos_dpath import jos_pkg::*; #(
  parameter int MAX_SIZE = MAX_SIZE_DEF
) (
  input  logic              clk,
  input  logic [SIZE_W-1:0] circle_size,
  input  logic [STEP_W-1:0] step_count,
  input  cmd_t              cmd,
  output status_t           status,
  output logic [OUT_W-1:0]  survivor
);

  localparam int CW    = $clog2(MAX_SIZE + 2);
  localparam int PW    = $clog2(MAX_SIZE);
  localparam int DW    = $clog2(MAX_SIZE + STEP_FULL);
  localparam int DWP   = DW + (DW % 2);
  localparam int NSTEP = DWP / 2;
  localparam int NW    = $clog2(NSTEP + 1);

  logic [CW-1:0]     size;
  logic [STEP_W:0]   step;
  logic [CW-1:0]     idx;
  logic [PW-1:0]     pos;
  logic [DWP-1:0]    dvd;
  logic [CW-1:0]     rem;
  logic [NW-1:0]     cnt;

  logic [31:0]       size_ext;
  logic [CW-1:0]     size_in;
  logic [STEP_W:0]   step_in;
  logic [CW:0]       r1, r2;
  logic [CW-1:0]     rem_a, rem_b;
  logic [PW:0]       pos_inc;

  // clamp the request into the supported range
  always_comb begin
    size_ext = 32'(circle_size);
    if (size_ext == 32'd0) begin
      size_in = CW'(1);
    end else if (size_ext > 32'(MAX_SIZE)) begin
      size_in = CW'(MAX_SIZE);
    end else begin
      size_in = CW'(size_ext);
    end
    if (step_count == '0) begin
      step_in = (STEP_W + 1)'(STEP_FULL);
    end else begin
      step_in = {1'b0, step_count};
    end
  end

  // two restoring steps: bring in the next dividend bit, subtract if it fits
  always_comb begin
    r1 = {rem, dvd[DWP-1]};
    if (r1 >= {1'b0, idx}) begin
      r1 = r1 - {1'b0, idx};
    end
    rem_a = r1[CW-1:0];
    r2 = {rem_a, dvd[DWP-2]};
    if (r2 >= {1'b0, idx}) begin
      r2 = r2 - {1'b0, idx};
    end
    rem_b = r2[CW-1:0];
  end

  assign pos_inc         = {1'b0, pos} + (PW + 1)'(1);
  assign status.done     = (idx > size);
  assign status.div_last = (cnt == NW'(1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      size <= size_in;
      step <= step_in;
      idx  <= CW'(2);
      pos  <= '0;
    end
    if (cmd.start) begin
      dvd <= DWP'(pos) + DWP'(step);
      rem <= '0;
      cnt <= NW'(NSTEP);
    end
    if (cmd.shift) begin
      dvd <= dvd << 2;
      rem <= rem_b;
      cnt <= cnt - NW'(1);
    end
    if (cmd.commit) begin
      pos <= PW'(rem_b);
      idx <= idx + CW'(1);
    end
    if (cmd.emit) begin
      survivor <= OUT_W'(pos_inc);
    end
  end

endmodule

>>> rtl/core/jos_checker.sv
// ---------------------------------------------------------------------------
// jos_checker
// Port-level checks for josephus_survivor, bound to the top level.
// ---------------------------------------------------------------------------
module jos_checker import jos_pkg::*; #(
  parameter int MAX_SIZE = MAX_SIZE_DEF
) (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic [SIZE_W-1:0] circle_size,
  input logic [STEP_W-1:0] step_count,
  input logic              out_valid,
  input logic              out_stall,
  input logic [OUT_W-1:0]  survivor
);

  // a stalled request holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(circle_size) && $stable(step_count))
    else $error("stalled request changed or dropped");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(survivor))
    else $error("stalled result changed or dropped");

  // a survivor lies between 1 and MAX_SIZE (checked when MAX_SIZE fits the output)
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (MAX_SIZE > 2047) ||
                  (survivor != '0 && 32'(survivor) <= 32'(MAX_SIZE)))
    else $error("survivor outside the circle");

  // a taken request leaves the block busy in the following cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request transfer did not occupy the block");

  // a new result only appears at the end of a busy period
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without work in progress");

endmodule

bind josephus_survivor jos_checker #(.MAX_SIZE(MAX_SIZE)) u_jos_checker (.*);
